// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the dashed line generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DDA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dda_pkg.sv =====
// Package for the dashed DDA line generator: widths, CSR codes, payload types,
// the back-end state enum and the fixed-point truncation helper. No dependencies.
package dda_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 1;
   localparam int INC_BITS   = FRAC_BITS + 2;
   localparam int QUO_BITS   = FRAC_BITS + 1;
   localparam int DASH_BITS  = COORD_BITS + 2;
   localparam int CFG_BITS   = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DASH_ON     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DASH_PERIOD = 2'd1;

   localparam logic [CFG_BITS-1:0] DASH_ON_RESET     = 8'd10;
   localparam logic [CFG_BITS-1:0] DASH_PERIOD_RESET = 8'd20;

   typedef struct packed {
      logic                         mode;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic                         visible;
      logic                         done_res;
   } rsp_type;

   // classified request as it sits in the queue
   typedef struct packed {
      logic                         is_load;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic                         x_neg;
      logic                         y_neg;
      logic [COORD_BITS-1:0]        x_abs;
      logic [COORD_BITS-1:0]        y_abs;
      logic [COORD_BITS-1:0]        step;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DIVIDE
   } back_state_type;

   // fixed-point position to integer, truncated toward zero
   function automatic logic signed [COORD_BITS-1:0] trunc_coord(
      input logic signed [POS_BITS-1:0] pos);
      logic [POS_BITS-FRAC_BITS-1:0] ip;
      ip = pos[POS_BITS-1:FRAC_BITS];
      if (pos[POS_BITS-1] && (|pos[FRAC_BITS-1:0])) begin
         ip = ip + (POS_BITS-FRAC_BITS)'(1);
      end
      return ip[COORD_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/dda_front.sv =====
// Front end: classifies a request and derives |dx|, |dy|, their signs and step.
// Depends on dda_pkg.
module dda_front (
   input  dda_pkg::req_type req_data,
   output dda_pkg::cmd_type cmd
);

   logic signed [dda_pkg::COORD_BITS:0] dx;
   logic signed [dda_pkg::COORD_BITS:0] dy;
   logic signed [dda_pkg::COORD_BITS:0] dx_mag;
   logic signed [dda_pkg::COORD_BITS:0] dy_mag;

   always_comb begin
      dx = {req_data.x_end[dda_pkg::COORD_BITS-1], req_data.x_end}
         - {req_data.x_start[dda_pkg::COORD_BITS-1], req_data.x_start};
      dy = {req_data.y_end[dda_pkg::COORD_BITS-1], req_data.y_end}
         - {req_data.y_start[dda_pkg::COORD_BITS-1], req_data.y_start};
      dx_mag = dx[dda_pkg::COORD_BITS] ? -dx : dx;
      dy_mag = dy[dda_pkg::COORD_BITS] ? -dy : dy;

      cmd.is_load = ~req_data.mode;
      cmd.x_start = req_data.x_start;
      cmd.y_start = req_data.y_start;
      cmd.x_neg   = dx[dda_pkg::COORD_BITS];
      cmd.y_neg   = dy[dda_pkg::COORD_BITS];
      cmd.x_abs   = dx_mag[dda_pkg::COORD_BITS-1:0];
      cmd.y_abs   = dy_mag[dda_pkg::COORD_BITS-1:0];
      cmd.step    = (cmd.x_abs > cmd.y_abs) ? cmd.x_abs : cmd.y_abs;
   end

endmodule

// ===== hw/rtl/dda_queue.sv =====
// Short command queue between front and back end.
// Depends on dda_pkg.
module dda_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dda_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             out_valid,
   output dda_pkg::cmd_type out_data
);

   localparam int PTR_BITS = $clog2(dda_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(dda_pkg::QUEUE_DEPTH + 1);

   dda_pkg::cmd_type entry_ff [dda_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(dda_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/dda_divider.sv =====
// Two-lane restoring divider: |d| * 2^FRAC_BITS / step, one quotient bit a cycle.
// Depends on dda_pkg.
module dda_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dda_pkg::COORD_BITS-1:0]    step,
   input  logic [dda_pkg::COORD_BITS-1:0]    x_abs,
   input  logic [dda_pkg::COORD_BITS-1:0]    y_abs,
   output dda_pkg::div_status_type           status,
   output logic [dda_pkg::QUO_BITS-1:0]      x_quo,
   output logic [dda_pkg::QUO_BITS-1:0]      y_quo
);

   localparam int CNT_BITS = $clog2(dda_pkg::QUO_BITS);
   localparam int REM_BITS = dda_pkg::COORD_BITS + 1;

   logic [REM_BITS-1:0]           x_rem_ff, x_rem_in, y_rem_ff, y_rem_in;
   logic [REM_BITS-1:0]           x_diff, y_diff;
   logic [dda_pkg::QUO_BITS-1:0]  x_quo_ff, x_quo_in, y_quo_ff, y_quo_in;
   logic [dda_pkg::COORD_BITS-1:0] step_ff, step_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   logic                          x_ge, y_ge;

   always_comb begin
      x_ge   = (x_rem_ff >= {1'b0, step_ff});
      y_ge   = (y_rem_ff >= {1'b0, step_ff});
      x_diff = x_ge ? x_rem_ff - {1'b0, step_ff} : x_rem_ff;
      y_diff = y_ge ? y_rem_ff - {1'b0, step_ff} : y_rem_ff;

      x_rem_in = x_rem_ff;
      y_rem_in = y_rem_ff;
      x_quo_in = x_quo_ff;
      y_quo_in = y_quo_ff;
      step_in  = step_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         x_rem_in = {1'b0, x_abs};
         y_rem_in = {1'b0, y_abs};
         x_quo_in = '0;
         y_quo_in = '0;
         step_in  = step;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         x_rem_in = {x_diff[REM_BITS-2:0], 1'b0};
         y_rem_in = {y_diff[REM_BITS-2:0], 1'b0};
         x_quo_in = {x_quo_ff[dda_pkg::QUO_BITS-2:0], x_ge};
         y_quo_in = {y_quo_ff[dda_pkg::QUO_BITS-2:0], y_ge};
         count_in = count_ff + CNT_BITS'(1);
         if (count_ff == CNT_BITS'(dda_pkg::FRAC_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      x_rem_ff <= x_rem_in;
      y_rem_ff <= y_rem_in;
      x_quo_ff <= x_quo_in;
      y_quo_ff <= y_quo_in;
      step_ff  <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign x_quo       = x_quo_ff;
   assign y_quo       = y_quo_ff;

endmodule

// ===== hw/rtl/dda_back.sv =====
// Back end: line state, dash tracking, dash CSRs and the response register.
// Depends on dda_pkg, dda_divider and assert_macros.svh.
`include "assert_macros.svh"

module dda_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   input  dda_pkg::cmd_type                     cmd,
   output logic                                 cmd_pop,
   input  logic                                 csr_write,
   input  logic [dda_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dda_pkg::CFG_BITS-1:0]         csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dda_pkg::rsp_type                     rsp_data
);

   localparam int C = dda_pkg::COORD_BITS;
   localparam int P = dda_pkg::POS_BITS;
   localparam int N = dda_pkg::INC_BITS;
   localparam int D = dda_pkg::DASH_BITS;

   dda_pkg::back_state_type state_ff, state_in;
   dda_pkg::div_status_type div_status;

   logic signed [P-1:0]   x_pos_ff, x_pos_in, y_pos_ff, y_pos_in;
   logic signed [N-1:0]   x_inc_ff, x_inc_in, y_inc_ff, y_inc_in;
   logic [C-1:0]          step_total_ff, step_total_in;
   logic [C-1:0]          step_index_ff, step_index_in;
   logic [D-1:0]          dash_start_ff, dash_start_in;
   logic                  line_finished_ff, line_finished_in;
   logic                  x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic [dda_pkg::CFG_BITS-1:0] dash_on_ff, dash_on_in;
   logic [dda_pkg::CFG_BITS-1:0] dash_period_ff, dash_period_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dda_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                  out_free, div_start, emit, emit_vis, emit_done;
   logic [C-1:0]          next_index;
   logic [dda_pkg::QUO_BITS-1:0] x_quo, y_quo;
   logic signed [N-1:0]   x_quo_ext, y_quo_ext;

   dda_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .step   (cmd.step),
      .x_abs  (cmd.x_abs),
      .y_abs  (cmd.y_abs),
      .status (div_status),
      .x_quo  (x_quo),
      .y_quo  (y_quo)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dda_pkg::BACK_IDLE: begin
            if (cmd_valid && out_free && cmd.is_load && (cmd.step != '0)) begin
               state_in = dda_pkg::BACK_DIVIDE;
            end
         end
         dda_pkg::BACK_DIVIDE: begin
            if (div_status.done) begin
               state_in = dda_pkg::BACK_IDLE;
            end
         end
         default: state_in = dda_pkg::BACK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop   = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         dda_pkg::BACK_IDLE: begin
            cmd_pop   = cmd_valid && out_free;
            div_start = cmd_valid && out_free && cmd.is_load && (cmd.step != '0);
         end
         dda_pkg::BACK_DIVIDE: begin
            cmd_pop   = 1'b0;
            div_start = 1'b0;
         end
         default: begin
            cmd_pop   = 1'b0;
            div_start = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      x_pos_in         = x_pos_ff;
      y_pos_in         = y_pos_ff;
      x_inc_in         = x_inc_ff;
      y_inc_in         = y_inc_ff;
      step_total_in    = step_total_ff;
      step_index_in    = step_index_ff;
      dash_start_in    = dash_start_ff;
      line_finished_in = line_finished_ff;
      x_neg_in         = x_neg_ff;
      y_neg_in         = y_neg_ff;
      dash_on_in       = dash_on_ff;
      dash_period_in   = dash_period_ff;
      emit             = 1'b0;
      emit_vis         = 1'b0;
      emit_done        = 1'b0;
      next_index       = step_index_ff + C'(1);
      x_quo_ext        = {1'b0, x_quo};
      y_quo_ext        = {1'b0, y_quo};

      if (csr_write) begin
         case (csr_index)
            dda_pkg::CSR_DASH_ON:     dash_on_in     = csr_wdata;
            dda_pkg::CSR_DASH_PERIOD: dash_period_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd_pop) begin
         emit = 1'b1;
         if (cmd.is_load) begin
            x_pos_in         = {cmd.x_start[C-1], cmd.x_start, {dda_pkg::FRAC_BITS{1'b0}}};
            y_pos_in         = {cmd.y_start[C-1], cmd.y_start, {dda_pkg::FRAC_BITS{1'b0}}};
            x_inc_in         = '0;
            y_inc_in         = '0;
            step_total_in    = cmd.step;
            step_index_in    = '0;
            dash_start_in    = '0;
            x_neg_in         = cmd.x_neg;
            y_neg_in         = cmd.y_neg;
            line_finished_in = (cmd.step == '0);
            emit_vis         = 1'b1;
            emit_done        = (cmd.step == '0);
         end else if (line_finished_ff) begin
            emit_done = 1'b1;
         end else begin
            step_index_in = next_index;
            if (next_index < step_total_ff) begin
               x_pos_in = x_pos_ff + {{(P-N){x_inc_ff[N-1]}}, x_inc_ff};
               y_pos_in = y_pos_ff + {{(P-N){y_inc_ff[N-1]}}, y_inc_ff};
               emit_vis = (D'(next_index) > dash_start_ff);
               if (D'(next_index) == dash_start_ff + D'(dash_on_ff)) begin
                  dash_start_in = dash_start_ff + D'(dash_period_ff);
               end
            end else begin
               line_finished_in = 1'b1;
               emit_vis         = (D'(step_total_ff) < dash_start_ff);
               emit_done        = 1'b1;
            end
         end
      end

      if ((state_ff == dda_pkg::BACK_DIVIDE) && div_status.done) begin
         x_inc_in = x_neg_ff ? -x_quo_ext : x_quo_ext;
         y_inc_in = y_neg_ff ? -y_quo_ext : y_quo_ext;
      end

      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_data_in.px       = dda_pkg::trunc_coord(x_pos_in);
         rsp_data_in.py       = dda_pkg::trunc_coord(y_pos_in);
         rsp_data_in.visible  = emit_vis;
         rsp_data_in.done_res = emit_done;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= dda_pkg::BACK_IDLE;
         x_pos_ff         <= '0;
         y_pos_ff         <= '0;
         x_inc_ff         <= '0;
         y_inc_ff         <= '0;
         step_total_ff    <= '0;
         step_index_ff    <= '0;
         dash_start_ff    <= '0;
         line_finished_ff <= 1'b1;
         dash_on_ff       <= dda_pkg::DASH_ON_RESET;
         dash_period_ff   <= dda_pkg::DASH_PERIOD_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         x_pos_ff         <= x_pos_in;
         y_pos_ff         <= y_pos_in;
         x_inc_ff         <= x_inc_in;
         y_inc_ff         <= y_inc_in;
         step_total_ff    <= step_total_in;
         step_index_ff    <= step_index_in;
         dash_start_ff    <= dash_start_in;
         line_finished_ff <= line_finished_in;
         dash_on_ff       <= dash_on_in;
         dash_period_ff   <= dash_period_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DDA_ASSERT_IMPLY(a_done_in_divide, clock, reset, div_status.done, state_ff == dda_pkg::BACK_DIVIDE, "divider done outside divide state")
   `DDA_ASSERT_IMPLY(a_idle_not_busy, clock, reset, state_ff == dda_pkg::BACK_IDLE, !div_status.busy, "divider busy while back end idle")
   `DDA_ASSERT_IMPLY(a_index_in_range, clock, reset, !line_finished_ff, step_index_ff < step_total_ff, "step index ran past step total")
   `DDA_ASSERT_NEXT(a_pop_gives_rsp, clock, reset, cmd_pop, rsp_valid_ff, "popped request produced no response")

endmodule

// ===== hw/rtl/dda_dashed_line_generator.sv =====
// Top level of the dashed DDA line generator.
// Depends on dda_pkg, dda_front, dda_queue and dda_back.
//
// Every request gives exactly one response. A load with a nonzero step starts the
// two-lane restoring divider, which yields one quotient bit per cycle; the back
// end takes no new request until the divide is done, and the start pixel leaves
// while the divide runs. A two-entry request queue sits between the classifying
// front end and the back end, and the response register lets the next request
// proceed as the previous response is taken. Dash CSRs may be written only when
// no request is outstanding; csr_ready is always high.
module dda_dashed_line_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dda_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dda_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dda_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dda_pkg::CFG_BITS-1:0]       csr_wdata
);

   dda_pkg::cmd_type front_cmd;
   dda_pkg::cmd_type queue_cmd;
   logic             queue_full, queue_valid, queue_pop;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;

   dda_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   dda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .out_valid (queue_valid),
      .out_data  (queue_cmd)
   );

   dda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
